### design/tfc_pkg.sv
// Shared constants and types for the two-way FIFO cache tag lookup unit.
`timescale 1ns / 1ps

package tfc_pkg;

  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned TAG_W           = 32;
  localparam int unsigned SET_W           = 10;
  localparam int unsigned MAX_SETS        = 1024;
  localparam int unsigned SLOT_W          = $clog2(MAX_SETS);
  localparam int unsigned OFFSET_CFG_W    = 5;
  localparam int unsigned SETBITS_CFG_W   = 4;
  localparam int unsigned CFG_DATA_W      = 5;
  localparam int unsigned CNT_W           = 32;

  localparam logic [OFFSET_CFG_W-1:0]  OFFSET_BITS_MAX   = 5'd16;
  localparam logic [SETBITS_CFG_W-1:0] IDX_BITS_MAX      = 4'd10;
  localparam logic [OFFSET_CFG_W-1:0]  OFFSET_BITS_RESET = 5'd2;
  localparam logic [SETBITS_CFG_W-1:0] IDX_BITS_RESET    = 4'd4;

  localparam logic CFG_OFFSET_BITS = 1'b0;
  localparam logic CFG_IDX_BITS    = 1'b1;

  typedef struct packed {
    logic newest_valid;
    logic older_valid;
    logic [TAG_W-1:0] newest_tag;
    logic [TAG_W-1:0] older_tag;
  } tfc_entry_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic commit;
  } tfc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } tfc_sts_t;

endpackage

### design/tfc_ctrl.sv
// Controller state machine: clearing pass, beat acceptance and lookup commit.
`timescale 1ns / 1ps

module tfc_ctrl import tfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tfc_sts_t sts_i,
  output tfc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } tfc_state_e;

  tfc_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.clear   = (state_q == ST_CLEAR);
  assign cmd_o.accept  = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.commit  = (state_q == ST_LOOKUP) && sts_i.out_free;

endmodule

### design/tfc_datapath.sv
// Datapath: address split, tag memory, compare, FIFO update, counters and output register.
`timescale 1ns / 1ps

module tfc_datapath import tfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ADDR_W-1:0]     address_i,
  input  tfc_cmd_t              cmd_i,
  output tfc_sts_t              sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_hit_o,
  output logic [SET_W-1:0]      set_index_o,
  output logic [TAG_W-1:0]      tag_value_o,
  output logic                  evicted_o,
  output logic [CNT_W-1:0]      hit_count_o,
  output logic [CNT_W-1:0]      miss_count_o
);

  logic [OFFSET_CFG_W-1:0]  offset_bits_q;
  logic [SETBITS_CFG_W-1:0] idx_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= OFFSET_BITS_RESET;
      idx_bits_q    <= IDX_BITS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_OFFSET_BITS) begin
        offset_bits_q <= cfg_data_i[OFFSET_CFG_W-1:0];
      end else begin
        idx_bits_q <= cfg_data_i[SETBITS_CFG_W-1:0];
      end
    end
  end

  logic [OFFSET_CFG_W-1:0]  ob;
  logic [SETBITS_CFG_W-1:0] sb;
  logic [5:0]               tag_shift;
  logic [SET_W-1:0]         set_mask;
  logic [SET_W-1:0]         set_c;
  logic [TAG_W-1:0]         tag_c;

  assign ob        = (offset_bits_q > OFFSET_BITS_MAX) ? OFFSET_BITS_MAX : offset_bits_q;
  assign sb        = (idx_bits_q > IDX_BITS_MAX) ? IDX_BITS_MAX : idx_bits_q;
  assign tag_shift = 6'(ob) + 6'(sb);
  assign set_mask  = SET_W'((11'd1 << sb) - 11'd1);
  assign set_c     = SET_W'(address_i >> ob) & set_mask;
  assign tag_c     = TAG_W'(address_i >> tag_shift);

  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      set_q <= set_c;
      tag_q <= tag_c;
    end
  end

  logic [SLOT_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  assign sts_o.clear_last = (clr_addr_q == SLOT_W'(MAX_SETS - 1));

  tfc_entry_t        mem [MAX_SETS];
  tfc_entry_t        rd_q;
  tfc_entry_t        wr_entry;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic              hit_newest;
  logic              hit_older;
  logic              hit;
  tfc_entry_t        upd_entry;

  assign hit_newest = rd_q.newest_valid && (rd_q.newest_tag == tag_q);
  assign hit_older  = rd_q.older_valid && (rd_q.older_tag == tag_q);
  assign hit        = hit_newest || hit_older;

  always_comb begin
    upd_entry              = rd_q;
    upd_entry.older_valid  = rd_q.newest_valid;
    upd_entry.older_tag    = rd_q.newest_tag;
    upd_entry.newest_valid = 1'b1;
    upd_entry.newest_tag   = tag_q;
  end

  assign mem_we    = cmd_i.clear || (cmd_i.commit && !hit);
  assign mem_waddr = cmd_i.clear ? clr_addr_q : SLOT_W'(set_q);
  assign wr_entry  = cmd_i.clear ? tfc_entry_t'('0) : upd_entry;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= wr_entry;
    end
    if (cmd_i.accept) begin
      rd_q <= mem[SLOT_W'(set_c)];
    end
  end

  logic [CNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0] miss_cnt_q, miss_cnt_d;

  always_comb begin
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (hit) begin
      if (hit_cnt_q != '1) hit_cnt_d = hit_cnt_q + 1'b1;
    end else begin
      if (miss_cnt_q != '1) miss_cnt_d = miss_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else if (cmd_i.commit) begin
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
    end
  end

  logic out_valid_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      is_hit_o     <= hit;
      set_index_o  <= set_q;
      tag_value_o  <= tag_q;
      evicted_o    <= !hit && rd_q.older_valid;
      hit_count_o  <= hit_cnt_d;
      miss_count_o <= miss_cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clear && (cmd_i.commit || cmd_i.accept)))
    else $error("Clearing pass overlaps a lookup.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.commit))
    else $error("Output beat appeared without a commit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !hit |=> $stable(hit_cnt_q) && (miss_cnt_q != '0))
    else $error("Miss commit updated the wrong counter.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(is_hit_o && evicted_o))
    else $error("Hit beat reports an eviction.");
`endif

endmodule

### design/two_way_fifo_cache_tag_lookup_unit.sv
// Top level of the two-way set-associative tag lookup with FIFO replacement.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_ready_o   address_i
//   out      output     out_valid_o/out_ready_i is_hit_o, set_index_o, tag_value_o,
//                                               evicted_o, hit_count_o, miss_count_o
//   cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// A beat is accepted in ST_IDLE, where its set is read from the single-port tag
// memory; in ST_LOOKUP it is compared, and a miss writes the updated set back.
// A lookup waits in ST_LOOKUP while the output register holds an untaken beat.
// After reset, a pass clears every set's valid bits; in_ready_o stays low meanwhile.
// Configuration writes take effect on the next cycle.
`timescale 1ns / 1ps

module two_way_fifo_cache_tag_lookup_unit import tfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ADDR_W-1:0]     address_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_hit_o,
  output logic [SET_W-1:0]      set_index_o,
  output logic [TAG_W-1:0]      tag_value_o,
  output logic                  evicted_o,
  output logic [CNT_W-1:0]      hit_count_o,
  output logic [CNT_W-1:0]      miss_count_o
);

  tfc_cmd_t cmd;
  tfc_sts_t sts;

  tfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tfc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .address_i    (address_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_hit_o     (is_hit_o),
    .set_index_o  (set_index_o),
    .tag_value_o  (tag_value_o),
    .evicted_o    (evicted_o),
    .hit_count_o  (hit_count_o),
    .miss_count_o (miss_count_o)
  );

endmodule
